// File: hw/rtl/fca_pkg.sv
package fca_pkg;

    localparam int BLOCK_COUNT = 1024;
    localparam int BLOCK_BYTES = 512;

    localparam int IDX_W   = $clog2(BLOCK_COUNT);
    localparam int CNT_W   = IDX_W + 1;
    localparam int LEN_W   = 19;
    localparam int ENTRY_W = 16;

    localparam logic [ENTRY_W-1:0] ENTRY_FREE = 16'hFFFF;
    localparam logic [ENTRY_W-1:0] ENTRY_END  = 16'hFFFE;

    typedef enum logic [1:0] {
        MODE_ALLOC  = 2'd0,
        MODE_FREE   = 2'd1,
        MODE_READ   = 2'd2,
        MODE_FORMAT = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_BAD_INDEX = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_WALK_RD,
        S_WALK_EV,
        S_READ,
        S_FORMAT,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_NOSPACE,
        DP_BADIDX,
        DP_FMT_START,
        DP_CLEAR,
        DP_SCAN,
        DP_LINK_END,
        DP_WALK_EV,
        DP_READ_EV
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   load_out;
    } t_dp_cmd;

    typedef struct packed {
        t_mode mode;
        logic  no_space;
        logic  bad_index;
        logic  scan_done;
        logic  walk_last;
        logic  clear_last;
    } t_dp_stat;

endpackage

// File: hw/rtl/fca_ifs.sv
interface fca_item_if;
    logic                          valid;
    logic                          ready;
    fca_pkg::t_mode                mode;
    logic [fca_pkg::LEN_W-1:0]     byte_length;
    logic [fca_pkg::IDX_W-1:0]     block_index;

    modport source (output valid, mode, byte_length, block_index, input ready);
    modport sink (input valid, mode, byte_length, block_index, output ready);
endinterface

interface fca_result_if;
    logic                          valid;
    logic                          ready;
    fca_pkg::t_status              status;
    logic [fca_pkg::IDX_W-1:0]     head_block;
    logic [fca_pkg::CNT_W-1:0]     blocks_changed;
    logic [fca_pkg::ENTRY_W-1:0]   entry_value;
    logic [fca_pkg::CNT_W-1:0]     free_count;

    modport source (output valid, status, head_block, blocks_changed, entry_value,
                    free_count, input ready);
    modport sink (input valid, status, head_block, blocks_changed, entry_value,
                  free_count, output ready);
endinterface

// File: hw/rtl/fca_ctrl.sv
module fca_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  fca_pkg::t_dp_stat i_stat,
    output fca_pkg::t_dp_cmd  o_cmd
);

    fca_pkg::t_state r_state;
    fca_pkg::t_state n_state;
    logic            r_out_vld;
    logic            n_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fca_pkg::S_CLEAR;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd.op        = fca_pkg::DP_NOP;
        o_cmd.load_out  = 1'b0;
        o_in_ready      = 1'b0;
        case (r_state)
            fca_pkg::S_CLEAR: begin
                o_cmd.op = fca_pkg::DP_CLEAR;
                if (i_stat.clear_last) begin
                    n_state = fca_pkg::S_IDLE;
                end
            end
            fca_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = fca_pkg::DP_LOAD;
                    n_state  = fca_pkg::S_DECODE;
                end
            end
            fca_pkg::S_DECODE: begin
                case (i_stat.mode)
                    fca_pkg::MODE_ALLOC: begin
                        if (i_stat.no_space) begin
                            o_cmd.op = fca_pkg::DP_NOSPACE;
                            n_state  = fca_pkg::S_DONE;
                        end else begin
                            n_state  = fca_pkg::S_SCAN;
                        end
                    end
                    fca_pkg::MODE_FREE: begin
                        if (i_stat.bad_index) begin
                            o_cmd.op = fca_pkg::DP_BADIDX;
                            n_state  = fca_pkg::S_DONE;
                        end else begin
                            // head entry is already on the read port
                            n_state  = fca_pkg::S_WALK_EV;
                        end
                    end
                    fca_pkg::MODE_READ: begin
                        if (i_stat.bad_index) begin
                            o_cmd.op = fca_pkg::DP_BADIDX;
                            n_state  = fca_pkg::S_DONE;
                        end else begin
                            n_state  = fca_pkg::S_READ;
                        end
                    end
                    default: begin
                        o_cmd.op = fca_pkg::DP_FMT_START;
                        n_state  = fca_pkg::S_FORMAT;
                    end
                endcase
            end
            fca_pkg::S_SCAN: begin
                if (i_stat.scan_done) begin
                    o_cmd.op = fca_pkg::DP_LINK_END;
                    n_state  = fca_pkg::S_DONE;
                end else begin
                    o_cmd.op = fca_pkg::DP_SCAN;
                end
            end
            fca_pkg::S_WALK_RD: begin
                n_state = fca_pkg::S_WALK_EV;
            end
            fca_pkg::S_WALK_EV: begin
                o_cmd.op = fca_pkg::DP_WALK_EV;
                n_state  = i_stat.walk_last ? fca_pkg::S_DONE : fca_pkg::S_WALK_RD;
            end
            fca_pkg::S_READ: begin
                o_cmd.op = fca_pkg::DP_READ_EV;
                n_state  = fca_pkg::S_DONE;
            end
            fca_pkg::S_FORMAT: begin
                o_cmd.op = fca_pkg::DP_CLEAR;
                if (i_stat.clear_last) begin
                    n_state = fca_pkg::S_DONE;
                end
            end
            fca_pkg::S_DONE: begin
                // hold until the output register is free
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = fca_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fca_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    assign o_out_valid = r_out_vld;

endmodule

// File: hw/rtl/fca_dpath.sv
module fca_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fca_pkg::t_dp_cmd              i_cmd,
    input  fca_pkg::t_mode                i_mode,
    input  logic [fca_pkg::LEN_W-1:0]     i_byte_length,
    input  logic [fca_pkg::IDX_W-1:0]     i_block_index,
    output fca_pkg::t_dp_stat             o_stat,
    output fca_pkg::t_status              o_status,
    output logic [fca_pkg::IDX_W-1:0]     o_head_block,
    output logic [fca_pkg::CNT_W-1:0]     o_blocks_changed,
    output logic [fca_pkg::ENTRY_W-1:0]   o_entry_value,
    output logic [fca_pkg::CNT_W-1:0]     o_free_count
);

    localparam int IDX_W   = fca_pkg::IDX_W;
    localparam int CNT_W   = fca_pkg::CNT_W;
    localparam int ENTRY_W = fca_pkg::ENTRY_W;
    localparam logic [CNT_W-1:0]   BLK_CNT   = CNT_W'(fca_pkg::BLOCK_COUNT);
    localparam logic [CNT_W-1:0]   BLK_LAST  = CNT_W'(fca_pkg::BLOCK_COUNT - 1);
    localparam logic [ENTRY_W-1:0] BLK_LIMIT = ENTRY_W'(fca_pkg::BLOCK_COUNT);

    logic [ENTRY_W-1:0] r_mem [fca_pkg::BLOCK_COUNT];
    logic [ENTRY_W-1:0] r_rdata;

    fca_pkg::t_mode     r_mode;
    fca_pkg::t_status   r_status;
    logic [CNT_W-1:0]   r_need;
    logic [CNT_W-1:0]   r_ptr;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_free;
    logic               r_eval_vld;
    logic [IDX_W-1:0]   r_eval_addr;
    logic [IDX_W-1:0]   r_prev;
    logic [IDX_W-1:0]   r_head;
    logic [ENTRY_W-1:0] r_entry;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;
    logic [CNT_W-1:0]   need_in;
    logic [CNT_W-1:0]   cnt_inc;
    logic               scan_hit;
    logic               entry_free;

    assign mem_raddr  = r_ptr[IDX_W-1:0];
    assign need_in    = CNT_W'(i_byte_length / fca_pkg::BLOCK_BYTES) + CNT_W'(1);
    assign cnt_inc    = r_cnt + CNT_W'(1);
    assign entry_free = (r_rdata == fca_pkg::ENTRY_FREE);
    assign scan_hit   = r_eval_vld && entry_free;

    assign o_stat.mode       = r_mode;
    assign o_stat.no_space   = (r_need > r_free);
    assign o_stat.bad_index  = (r_ptr >= BLK_CNT);
    assign o_stat.scan_done  = (r_cnt == r_need);
    // the end mark and a broken link both fall at or above the table size
    assign o_stat.walk_last  = entry_free || (r_rdata >= BLK_LIMIT) || (cnt_inc == r_need);
    assign o_stat.clear_last = (r_ptr == BLK_LAST);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_ptr[IDX_W-1:0];
        mem_wdata = fca_pkg::ENTRY_FREE;
        case (i_cmd.op)
            fca_pkg::DP_SCAN: begin
                // link the previous block of the chain to this one
                mem_we    = scan_hit && (r_cnt != '0);
                mem_waddr = r_prev;
                mem_wdata = ENTRY_W'(r_eval_addr);
            end
            fca_pkg::DP_LINK_END: begin
                mem_we    = 1'b1;
                mem_waddr = r_prev;
                mem_wdata = fca_pkg::ENTRY_END;
            end
            fca_pkg::DP_WALK_EV: begin
                mem_we    = !entry_free;
            end
            fca_pkg::DP_CLEAR: begin
                mem_we    = 1'b1;
            end
            default: begin
                mem_we    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr      <= '0;
            r_eval_vld <= 1'b0;
            r_free     <= BLK_CNT;
        end else begin
            case (i_cmd.op)
                fca_pkg::DP_LOAD: begin
                    r_mode     <= i_mode;
                    r_need     <= need_in;
                    r_status   <= fca_pkg::ST_OK;
                    r_cnt      <= '0;
                    r_head     <= '0;
                    r_entry    <= '0;
                    r_eval_vld <= 1'b0;
                    if (i_mode inside {fca_pkg::MODE_FREE, fca_pkg::MODE_READ}) begin
                        r_ptr <= CNT_W'(i_block_index);
                    end else begin
                        r_ptr <= '0;
                    end
                end
                fca_pkg::DP_NOSPACE: begin
                    r_status <= fca_pkg::ST_NO_SPACE;
                end
                fca_pkg::DP_BADIDX: begin
                    r_status <= fca_pkg::ST_BAD_INDEX;
                end
                fca_pkg::DP_FMT_START: begin
                    r_cnt <= BLK_CNT - r_free;
                    r_ptr <= '0;
                end
                fca_pkg::DP_CLEAR: begin
                    r_ptr  <= r_ptr + CNT_W'(1);
                    r_free <= BLK_CNT;
                end
                fca_pkg::DP_SCAN: begin
                    // issue the next read while the previous one is evaluated
                    if (r_ptr < BLK_CNT) begin
                        r_ptr       <= r_ptr + CNT_W'(1);
                        r_eval_vld  <= 1'b1;
                        r_eval_addr <= r_ptr[IDX_W-1:0];
                    end else begin
                        r_eval_vld  <= 1'b0;
                    end
                    if (scan_hit) begin
                        if (r_cnt == '0) begin
                            r_head <= r_eval_addr;
                        end
                        r_prev <= r_eval_addr;
                        r_cnt  <= cnt_inc;
                    end
                end
                fca_pkg::DP_LINK_END: begin
                    r_free <= r_free - r_cnt;
                end
                fca_pkg::DP_WALK_EV: begin
                    if (!entry_free) begin
                        r_free <= r_free + CNT_W'(1);
                        r_cnt  <= cnt_inc;
                        r_ptr  <= CNT_W'(r_rdata);
                    end
                end
                fca_pkg::DP_READ_EV: begin
                    r_entry <= r_rdata;
                end
                default: begin
                    r_eval_vld <= r_eval_vld;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_status         <= r_status;
            o_head_block     <= r_head;
            o_blocks_changed <= r_cnt;
            o_entry_value    <= r_entry;
            o_free_count     <= r_free;
        end
    end

endmodule

// File: hw/rtl/fat_chain_allocator.sv
// Block allocation table with chain allocate, chain free, entry read and format.
// i_item carries one request word (mode, byte_length, block_index) on a
// valid/ready handshake; o_result returns exactly one result word per request
// (status, head_block, blocks_changed, entry_value, free_count).
// Allocate scans the table one entry per cycle from block 0 and stops once the
// chain is complete. Free walks the chain one block at a time, alternating a
// read state and an evaluate state, as each link read must land before the next
// address is known. Format writes one table entry per cycle. The table memory
// has one write port and one registered read port. After reset a clearing pass
// marks all 1024 entries free; i_item.ready stays low during that pass. Requests
// are taken one at a time.
// The result sits in an output register: a new request is accepted while the
// previous result still waits, and if the receiver stalls the block finishes
// the next operation and then holds until the output register is taken.
module fat_chain_allocator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fca_item_if.sink      i_item,
    fca_result_if.source  o_result
);

    fca_pkg::t_dp_cmd  cmd;
    fca_pkg::t_dp_stat stat;

    fca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    fca_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_mode           (i_item.mode),
        .i_byte_length    (i_item.byte_length),
        .i_block_index    (i_item.block_index),
        .o_stat           (stat),
        .o_status         (o_result.status),
        .o_head_block     (o_result.head_block),
        .o_blocks_changed (o_result.blocks_changed),
        .o_entry_value    (o_result.entry_value),
        .o_free_count     (o_result.free_count)
    );

endmodule

// File: tb/fat_chain_allocator_tb.sv
module fat_chain_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W       = fca_pkg::IDX_W;
    localparam int CNT_W       = fca_pkg::CNT_W;
    localparam int LEN_W       = fca_pkg::LEN_W;
    localparam int ENTRY_W     = fca_pkg::ENTRY_W;
    localparam int BLOCK_COUNT = fca_pkg::BLOCK_COUNT;
    localparam int BLOCK_BYTES = fca_pkg::BLOCK_BYTES;
    localparam logic [ENTRY_W-1:0] ENTRY_FREE = fca_pkg::ENTRY_FREE;
    localparam logic [ENTRY_W-1:0] ENTRY_END  = fca_pkg::ENTRY_END;

    localparam int STALL_LIMIT = 12000;
    localparam int RANDOM_ITEMS = 550;
    localparam int CALM_FROM = 490;
    localparam int SETTLE_CYCLES = 64;

    typedef struct packed {
        fca_pkg::t_status    status;
        logic [IDX_W-1:0]    head_block;
        logic [CNT_W-1:0]    blocks_changed;
        logic [ENTRY_W-1:0]  entry_value;
        logic [CNT_W-1:0]    free_count;
    } t_fca_result;

    typedef struct {
        int head;
        int blocks;
    } t_chain;

    // Mirror of the allocation table plus the queue of results still owed.
    class fat_tracker;
        logic [ENTRY_W-1:0] fat [BLOCK_COUNT];
        int                 free_left;
        t_fca_result        expected_results [$];
        int                 mismatches;

        function new();
            foreach (fat[i]) fat[i] = ENTRY_FREE;
            free_left  = BLOCK_COUNT;
            mismatches = 0;
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

        function t_fca_result take_request(fca_pkg::t_mode mode, logic [LEN_W-1:0] len,
                                           logic [IDX_W-1:0] idx);
            t_fca_result r;
            int need, taken, prev, cur, nxt, changed;
            r       = '0;
            r.status = fca_pkg::ST_OK;
            need    = int'(len) / BLOCK_BYTES + 1;
            changed = 0;
            case (mode)
                fca_pkg::MODE_ALLOC: begin
                    if (need > free_left) begin
                        r.status = fca_pkg::ST_NO_SPACE;
                    end else begin
                        taken = 0;
                        prev  = 0;
                        // link the lowest free blocks in ascending order
                        for (int i = 0; i < BLOCK_COUNT && taken < need; i++) begin
                            if (fat[i] == ENTRY_FREE) begin
                                if (taken == 0)
                                    r.head_block = IDX_W'(i);
                                else
                                    fat[prev] = ENTRY_W'(i);
                                fat[i] = ENTRY_END;
                                prev   = i;
                                taken++;
                            end
                        end
                        free_left -= taken;
                        changed    = taken;
                    end
                end
                fca_pkg::MODE_FREE: begin
                    if (int'(idx) >= BLOCK_COUNT) begin
                        r.status = fca_pkg::ST_BAD_INDEX;
                    end else begin
                        cur = int'(idx);
                        while (changed < need) begin
                            nxt = int'(fat[cur]);
                            // stop on an already free block so nothing is counted twice
                            if (nxt == int'(ENTRY_FREE))
                                break;
                            fat[cur] = ENTRY_FREE;
                            free_left++;
                            changed++;
                            if (nxt == int'(ENTRY_END) || nxt >= BLOCK_COUNT)
                                break;
                            cur = nxt;
                        end
                    end
                end
                fca_pkg::MODE_READ: begin
                    if (int'(idx) >= BLOCK_COUNT)
                        r.status = fca_pkg::ST_BAD_INDEX;
                    else
                        r.entry_value = fat[idx];
                end
                default: begin
                    changed = BLOCK_COUNT - free_left;
                    foreach (fat[i]) fat[i] = ENTRY_FREE;
                    free_left = BLOCK_COUNT;
                end
            endcase
            r.blocks_changed = CNT_W'(changed);
            r.free_count     = CNT_W'(free_left);
            expected_results.push_back(r);
            return r;
        endfunction

        function void check_result(t_fca_result got);
            t_fca_result want;
            if (expected_results.size() == 0) begin
                $error("result word with no request pending");
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.head_block !== want.head_block) begin
                $error("head_block: expected %0d, got %0d", want.head_block, got.head_block);
                mismatches++;
            end
            if (got.blocks_changed !== want.blocks_changed) begin
                $error("blocks_changed: expected %0d, got %0d",
                       want.blocks_changed, got.blocks_changed);
                mismatches++;
            end
            if (got.entry_value !== want.entry_value) begin
                $error("entry_value: expected %h, got %h", want.entry_value, got.entry_value);
                mismatches++;
            end
            if (got.free_count !== want.free_count) begin
                $error("free_count: expected %0d, got %0d", want.free_count, got.free_count);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    fca_item_if   req_if ();
    fca_result_if res_if ();

    fat_chain_allocator u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (req_if),
        .o_result (res_if)
    );

    fat_tracker board;
    t_chain     live_chains [$];
    bit         calm = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        t_fca_result got;
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            got.status         = res_if.status;
            got.head_block     = res_if.head_block;
            got.blocks_changed = res_if.blocks_changed;
            got.entry_value    = res_if.entry_value;
            got.free_count     = res_if.free_count;
            board.check_result(got);
        end
    end

    // Receiver: stall in bursts, none once the run goes calm.
    initial begin : result_side
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(negedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                repeat ($urandom_range(0, 20)) @(negedge i_clk);
            end
        end
    end

    initial begin : watchdog
        int silent;
        silent = 0;
        while (silent < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
                (res_if.valid === 1'b1 && res_if.ready === 1'b1))
                silent = 0;
            else
                silent++;
        end
        $display("FAIL");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic issue(input fca_pkg::t_mode mode, input logic [LEN_W-1:0] len,
                         input logic [IDX_W-1:0] idx);
        t_fca_result r;
        if (!calm && $urandom_range(0, 5) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.mode        <= mode;
        req_if.byte_length <= len;
        req_if.block_index <= idx;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        r = board.take_request(mode, len, idx);
        if (mode == fca_pkg::MODE_ALLOC && r.status == fca_pkg::ST_OK)
            live_chains.push_back('{int'(r.head_block), int'(r.blocks_changed)});
        if (mode == fca_pkg::MODE_FORMAT)
            live_chains.delete();
        @(negedge i_clk);
    endtask

    // Hold the sender until every owed result has been taken.
    task automatic drain();
        req_if.valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic random_request();
        int               pick, slot, size_class;
        logic [LEN_W-1:0] len;
        t_chain           ch;
        pick = $urandom_range(0, 99);
        if (pick < 1) begin
            issue(fca_pkg::MODE_FORMAT, LEN_W'($urandom), IDX_W'($urandom));
        end else if (pick < 38) begin
            size_class = $urandom_range(0, 19);
            if (size_class < 12)
                len = LEN_W'($urandom_range(0, 4095));
            else if (size_class < 18)
                len = LEN_W'($urandom_range(0, 65535));
            else
                len = LEN_W'($urandom);
            issue(fca_pkg::MODE_ALLOC, len, IDX_W'($urandom));
        end else if (pick < 68 && live_chains.size() > 0) begin
            slot = $urandom_range(0, live_chains.size() - 1);
            ch   = live_chains[slot];
            case ($urandom_range(0, 3))
                0, 1: len = LEN_W'((ch.blocks - 1) * BLOCK_BYTES + $urandom_range(0, 511));
                2:    len = LEN_W'($urandom_range(0, ch.blocks - 1) * BLOCK_BYTES);
                default: len = LEN_W'($urandom);
            endcase
            // now and then keep a stale head so a later free walks into freed blocks
            if ($urandom_range(0, 9) != 0)
                live_chains.delete(slot);
            issue(fca_pkg::MODE_FREE, len, IDX_W'(ch.head));
        end else if (pick < 78) begin
            issue(fca_pkg::MODE_FREE, LEN_W'($urandom), IDX_W'($urandom));
        end else if (live_chains.size() > 0 && $urandom_range(0, 1) == 0) begin
            ch = live_chains[$urandom_range(0, live_chains.size() - 1)];
            issue(fca_pkg::MODE_READ, LEN_W'($urandom), IDX_W'(ch.head));
        end else begin
            issue(fca_pkg::MODE_READ, LEN_W'($urandom), IDX_W'($urandom));
        end
    endtask

    initial begin : stimulus
        board              = new();
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.mode        = fca_pkg::MODE_ALLOC;
        req_if.byte_length = '0;
        req_if.block_index = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, length limit, walk into a free block, no space.
        issue(fca_pkg::MODE_READ,   19'd0,       10'd0);
        issue(fca_pkg::MODE_READ,   19'd0,       10'd1023);
        issue(fca_pkg::MODE_ALLOC,  19'd0,       10'd0);
        issue(fca_pkg::MODE_ALLOC,  19'd511,     10'd0);
        issue(fca_pkg::MODE_ALLOC,  19'd512,     10'd0);
        issue(fca_pkg::MODE_ALLOC,  19'd1535,    10'd0);
        issue(fca_pkg::MODE_READ,   19'd0,       10'd4);
        issue(fca_pkg::MODE_FREE,   19'd0,       10'd4);
        issue(fca_pkg::MODE_FREE,   19'd524287,  10'd5);
        issue(fca_pkg::MODE_FREE,   19'd1024,    10'd4);
        issue(fca_pkg::MODE_FREE,   19'd511,     10'd2);
        issue(fca_pkg::MODE_READ,   19'd0,       10'd3);
        issue(fca_pkg::MODE_ALLOC,  19'd1023,    10'd0);
        issue(fca_pkg::MODE_READ,   19'd0,       10'd2);
        issue(fca_pkg::MODE_ALLOC,  19'd524287,  10'd1023);
        issue(fca_pkg::MODE_FORMAT, 19'd0,       10'd0);
        issue(fca_pkg::MODE_ALLOC,  19'd524287,  10'd0);
        issue(fca_pkg::MODE_READ,   19'd524287,  10'd1023);
        issue(fca_pkg::MODE_ALLOC,  19'd0,       10'd0);
        issue(fca_pkg::MODE_FREE,   19'd524287,  10'd0);
        issue(fca_pkg::MODE_ALLOC,  19'h2AAAA,   10'h2AA);
        issue(fca_pkg::MODE_ALLOC,  19'h55555,   10'h155);
        issue(fca_pkg::MODE_FREE,   19'h55555,   10'h3FF);
        issue(fca_pkg::MODE_FORMAT, 19'd524287,  10'd1023);
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2)
                drain();
            if (n == CALM_FROM) begin
                drain();
                calm = 1'b1;
            end
            random_request();
        end

        req_if.valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
